/* rtl/mdh_pkg.sv */
// Shared types, constants and arithmetic helpers for the modified DH transform.
`timescale 1ns / 1ps

package mdh_pkg;

    localparam int ANGLE_W          = 16;
    localparam int LEN_W            = 16;
    localparam int ENTRY_W          = 18;
    localparam int ROW_W            = 2;
    localparam int Z_W              = 45;
    localparam int TRIG_W           = 32;
    localparam int PROD_W           = 33;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH      = 4;
    localparam int PTR_W            = $clog2(QUEUE_DEPTH);
    localparam int CNT_W            = $clog2(QUEUE_DEPTH + 1);

    // Angles inside the rotator are radians at scale 2^-40.
    localparam logic signed [Z_W-1:0] PI_Z      = 45'sh3243F6A8886;
    localparam logic signed [Z_W-1:0] HALF_PI_Z = 45'sh1921FB54443;
    localparam logic signed [TRIG_W-1:0] GAIN   = 32'sh26DD3B6A;

    localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;
    localparam logic signed [ENTRY_W-1:0] ENTRY_ONE = 18'sd16384;
    localparam logic signed [47:0] ENTRY_MAX = 48'sd131071;
    localparam logic signed [47:0] ENTRY_MIN = -48'sd131072;

    // Arctangent series at scale 2^-62 for the steps that need many terms.
    localparam logic [63:0] ATAN1_ACC =
          (64'd1 << 61) / 64'd1  - (64'd1 << 59) / 64'd3  + (64'd1 << 57) / 64'd5
        - (64'd1 << 55) / 64'd7  + (64'd1 << 53) / 64'd9  - (64'd1 << 51) / 64'd11
        + (64'd1 << 49) / 64'd13 - (64'd1 << 47) / 64'd15 + (64'd1 << 45) / 64'd17
        - (64'd1 << 43) / 64'd19 + (64'd1 << 41) / 64'd21 - (64'd1 << 39) / 64'd23
        + (64'd1 << 37) / 64'd25 - (64'd1 << 35) / 64'd27 + (64'd1 << 33) / 64'd29
        - (64'd1 << 31) / 64'd31 + (64'd1 << 29) / 64'd33 - (64'd1 << 27) / 64'd35
        + (64'd1 << 25) / 64'd37 - (64'd1 << 23) / 64'd39 + (64'd1 << 21) / 64'd41
        - (64'd1 << 19) / 64'd43 + (64'd1 << 17) / 64'd45 - (64'd1 << 15) / 64'd47
        + (64'd1 << 13) / 64'd49 - (64'd1 << 11) / 64'd51 + (64'd1 << 9) / 64'd53
        - (64'd1 << 7) / 64'd55  + (64'd1 << 5) / 64'd57  - (64'd1 << 3) / 64'd59
        + (64'd1 << 1) / 64'd61;
    localparam logic [63:0] ATAN2_ACC =
          (64'd1 << 60) / 64'd1  - (64'd1 << 56) / 64'd3  + (64'd1 << 52) / 64'd5
        - (64'd1 << 48) / 64'd7  + (64'd1 << 44) / 64'd9  - (64'd1 << 40) / 64'd11
        + (64'd1 << 36) / 64'd13 - (64'd1 << 32) / 64'd15 + (64'd1 << 28) / 64'd17
        - (64'd1 << 24) / 64'd19 + (64'd1 << 20) / 64'd21 - (64'd1 << 16) / 64'd23
        + (64'd1 << 12) / 64'd25 - (64'd1 << 8) / 64'd27  + (64'd1 << 4) / 64'd29
        - (64'd1 << 0) / 64'd31;
    localparam logic [63:0] ATAN3_ACC =
          (64'd1 << 59) / 64'd1  - (64'd1 << 53) / 64'd3  + (64'd1 << 47) / 64'd5
        - (64'd1 << 41) / 64'd7  + (64'd1 << 35) / 64'd9  - (64'd1 << 29) / 64'd11
        + (64'd1 << 23) / 64'd13 - (64'd1 << 17) / 64'd15 + (64'd1 << 11) / 64'd17
        - (64'd1 << 5) / 64'd19;
    localparam logic [63:0] ATAN1 = (ATAN1_ACC + (64'd1 << 21)) >> 22;
    localparam logic [63:0] ATAN2 = (ATAN2_ACC + (64'd1 << 21)) >> 22;
    localparam logic [63:0] ATAN3 = (ATAN3_ACC + (64'd1 << 21)) >> 22;

    typedef logic signed [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  flip;
    } angle_t;

    typedef struct packed {
        logic signed [LEN_W-1:0] d;
        logic signed [LEN_W-1:0] r;
        logic signed [LEN_W-1:0] b;
    } len_t;

    typedef struct packed {
        angle_t q;
        angle_t a;
        angle_t g;
        len_t   len;
    } job_t;

    typedef struct packed {
        entry_t c0;
        entry_t c1;
        entry_t c2;
        entry_t c3;
    } row_t;

    // atan(2^-idx) at scale 2^-40
    function automatic logic [Z_W-1:0] atan_z(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        v = '0;
        unique case (idx)
            5'd0:    v = 45'hC90FDAA221;
            5'd1:    v = Z_W'(ATAN1);
            5'd2:    v = Z_W'(ATAN2);
            5'd3:    v = Z_W'(ATAN3);
            5'd4:    v = 45'd68630207382;
            5'd5:    v = 45'd34348560106;
            5'd6:    v = 45'd17178471287;
            5'd7:    v = 45'd8589759836;
            5'd8:    v = 45'd4294945451;
            5'd9:    v = 45'd2147480917;
            5'd10:   v = 45'd1073741483;
            5'd11:   v = 45'd536870869;
            5'd12:   v = 45'd268435451;
            5'd13:   v = 45'd134217727;
            default: v[40 - int'(idx)] = 1'b1;
        endcase
        return v;
    endfunction

    // Q30 product rounded to Q30
    function automatic logic signed [PROD_W-1:0] mul30(input logic signed [PROD_W-1:0] a,
                                                       input logic signed [PROD_W-1:0] b);
        logic signed [2*PROD_W-1:0] p;
        p = a * b + (66'sd1 <<< 29);
        return p[PROD_W+29:30];
    endfunction

    function automatic logic signed [47:0] rot_round(input logic signed [PROD_W:0] v);
        logic signed [47:0] w;
        w = 48'(v) + 48'sd32768;
        return w >>> 16;
    endfunction

    function automatic logic signed [47:0] len_round(input logic signed [49:0] v);
        logic signed [49:0] w;
        w = v + (50'sd1 <<< 29);
        return 48'(w >>> 30);
    endfunction

    function automatic entry_t sat_entry(input logic signed [47:0] v);
        entry_t e;
        priority if (v > ENTRY_MAX)
            e = ENTRY_MAX[ENTRY_W-1:0];
        else if (v < ENTRY_MIN)
            e = ENTRY_MIN[ENTRY_W-1:0];
        else
            e = v[ENTRY_W-1:0];
        return e;
    endfunction

endpackage

/* rtl/mdh_if.sv */
// Valid/ready channel interfaces for joint items and matrix row items.
`timescale 1ns / 1ps

interface mdh_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mdh_pkg::ANGLE_W-1:0]   joint_angle;
    logic signed [mdh_pkg::ANGLE_W-1:0]   twist_alpha;
    logic signed [mdh_pkg::ANGLE_W-1:0]   offset_gamma;
    logic signed [mdh_pkg::LEN_W-1:0]     length_d;
    logic signed [mdh_pkg::LEN_W-1:0]     offset_r;
    logic signed [mdh_pkg::LEN_W-1:0]     offset_b;

    modport source (output valid, joint_angle, twist_alpha, offset_gamma,
                    length_d, offset_r, offset_b, input ready);
    modport sink   (input valid, joint_angle, twist_alpha, offset_gamma,
                    length_d, offset_r, offset_b, output ready);
endinterface

interface mdh_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [mdh_pkg::ROW_W-1:0]            row_index;
    logic signed [mdh_pkg::ENTRY_W-1:0]   entry_first;
    logic signed [mdh_pkg::ENTRY_W-1:0]   entry_second;
    logic signed [mdh_pkg::ENTRY_W-1:0]   entry_third;
    logic signed [mdh_pkg::ENTRY_W-1:0]   entry_fourth;
    logic                                 last_row;

    modport source (output valid, row_index, entry_first, entry_second, entry_third,
                    entry_fourth, last_row, input ready);
    modport sink   (input valid, row_index, entry_first, entry_second, entry_third,
                    entry_fourth, last_row, output ready);
endinterface

/* rtl/mdh_front.sv */
// Front end: folds angles into the rotator range and queues joint items.
`timescale 1ns / 1ps

module mdh_front (
    input  logic            clk,
    input  logic            rst_n,
    mdh_in_if.sink          joint,
    output mdh_pkg::job_t   head,
    output logic            head_valid,
    input  logic            pop
);

    mdh_pkg::job_t                  q_reg [mdh_pkg::QUEUE_DEPTH];
    logic [mdh_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [mdh_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [mdh_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           push;
    mdh_pkg::job_t                  entry;

    // Bring the angle within a quarter turn; flag a sign flip of sin and cos.
    function automatic mdh_pkg::angle_t fold(input logic signed [mdh_pkg::ANGLE_W-1:0] ang);
        logic signed [mdh_pkg::Z_W-1:0] z;
        mdh_pkg::angle_t                o;
        z = mdh_pkg::Z_W'(ang) <<< 27;
        priority if (z > mdh_pkg::HALF_PI_Z)
        begin
            o.z    = z - mdh_pkg::PI_Z;
            o.flip = 1'b1;
        end
        else if (z < -mdh_pkg::HALF_PI_Z)
        begin
            o.z    = z + mdh_pkg::PI_Z;
            o.flip = 1'b1;
        end
        else
        begin
            o.z    = z;
            o.flip = 1'b0;
        end
        return o;
    endfunction

    assign joint.ready = (cnt_reg != mdh_pkg::CNT_W'(mdh_pkg::QUEUE_DEPTH));
    assign push        = joint.valid && joint.ready;
    assign head_valid  = (cnt_reg != '0);
    assign head        = q_reg[rd_ptr_reg];

    always_comb
    begin
        entry.q     = fold(joint.joint_angle);
        entry.a     = fold(joint.twist_alpha);
        entry.g     = fold(joint.offset_gamma);
        entry.len.d = joint.length_d;
        entry.len.r = joint.offset_r;
        entry.len.b = joint.offset_b;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mdh_pkg::CNT_W'(mdh_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a pushed item");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == mdh_pkg::CNT_W'(mdh_pkg::QUEUE_DEPTH) |-> !joint.ready)
        else $error("full queue still accepting items");

endmodule

/* rtl/mdh_cordic.sv */
// Pipelined CORDIC rotator: one iteration per stage, sine and cosine in Q30.
`timescale 1ns / 1ps

module mdh_cordic #(
    parameter int STEPS = mdh_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                adv,
    input  mdh_pkg::angle_t                     ang,
    output logic signed [mdh_pkg::TRIG_W-1:0]   sin_v,
    output logic signed [mdh_pkg::TRIG_W-1:0]   cos_v
);

    logic signed [mdh_pkg::TRIG_W-1:0] x_reg [STEPS];
    logic signed [mdh_pkg::TRIG_W-1:0] y_reg [STEPS];
    logic signed [mdh_pkg::Z_W-1:0]    z_reg [STEPS];
    logic                              f_reg [STEPS];
    logic signed [mdh_pkg::TRIG_W-1:0] x_next [STEPS];
    logic signed [mdh_pkg::TRIG_W-1:0] y_next [STEPS];
    logic signed [mdh_pkg::Z_W-1:0]    z_next [STEPS];
    logic                              f_next [STEPS];

    always_comb
    begin
        logic signed [mdh_pkg::TRIG_W-1:0] x_in;
        logic signed [mdh_pkg::TRIG_W-1:0] y_in;
        logic signed [mdh_pkg::Z_W-1:0]    z_in;
        logic                              f_in;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                x_in = mdh_pkg::GAIN;
                y_in = '0;
                z_in = ang.z;
                f_in = ang.flip;
            end
            else
            begin
                x_in = x_reg[i-1];
                y_in = y_reg[i-1];
                z_in = z_reg[i-1];
                f_in = f_reg[i-1];
            end
            // rotate toward zero residual angle
            if (!z_in[mdh_pkg::Z_W-1])
            begin
                x_next[i] = x_in - (y_in >>> i);
                y_next[i] = y_in + (x_in >>> i);
                z_next[i] = z_in - $signed(mdh_pkg::atan_z(5'(i)));
            end
            else
            begin
                x_next[i] = x_in + (y_in >>> i);
                y_next[i] = y_in - (x_in >>> i);
                z_next[i] = z_in + $signed(mdh_pkg::atan_z(5'(i)));
            end
            f_next[i] = f_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
                f_reg[i] <= f_next[i];
            end
        end
    end

    assign sin_v = f_reg[STEPS-1] ? -y_reg[STEPS-1] : y_reg[STEPS-1];
    assign cos_v = f_reg[STEPS-1] ? -x_reg[STEPS-1] : x_reg[STEPS-1];

endmodule

/* rtl/mdh_back.sv */
// Back end: three rotators, matrix products and the row-by-row output stage.
`timescale 1ns / 1ps

module mdh_back #(
    parameter int STEPS = mdh_pkg::CORDIC_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mdh_pkg::job_t   job,
    input  logic            job_valid,
    output logic            job_pop,
    mdh_out_if.source       matrix
);

    localparam int P = mdh_pkg::PROD_W;

    logic                               adv;
    logic                               take;
    logic                               fire;
    logic [STEPS-1:0]                   cv_reg;
    mdh_pkg::len_t                      ln_reg [STEPS];
    logic signed [mdh_pkg::TRIG_W-1:0]  sq, cq, sa, ca, sg, cg;

    // trig stage
    logic                               tv_reg;
    logic signed [P-1:0]                sq_reg, cq_reg, sa_reg, ca_reg, sg_reg, cg_reg;
    mdh_pkg::len_t                      tl_reg;

    // first product stage
    logic                               v1_reg;
    logic signed [P-1:0]                sgca_reg, cgca_reg, sgsa_reg, cgsa_reg;
    logic signed [P-1:0]                cgcq_reg, cgsq_reg, sgcq_reg, sgsq_reg;
    logic signed [P-1:0]                sasq_reg, sacq_reg, sq1_reg, cq1_reg, ca1_reg;
    logic signed [47:0]                 dcg_reg, dsg_reg, rca_reg;
    logic signed [mdh_pkg::LEN_W-1:0]   r1_reg, b1_reg;

    // second product stage
    logic                               v2_reg;
    logic signed [P-1:0]                sgcasq_reg, sgcacq_reg, cgcasq_reg, cgcacq_reg;
    logic signed [P-1:0]                cgcq2_reg, cgsq2_reg, sgcq2_reg, sgsq2_reg;
    logic signed [P-1:0]                sasq2_reg, sacq2_reg, sgsa2_reg, cgsa2_reg, ca2_reg;
    logic signed [48:0]                 rsgsa_reg, rcgsa_reg;
    logic signed [47:0]                 dcg2_reg, dsg2_reg, rca2_reg;
    logic signed [mdh_pkg::LEN_W-1:0]   b2_reg;

    // finished matrix and output stage
    logic                               v3_reg;
    mdh_pkg::row_t                      m3_reg [3];
    mdh_pkg::row_t                      m3_next [3];
    mdh_pkg::row_t                      mat_reg [3];
    logic                               full_reg, full_next;
    logic [mdh_pkg::ROW_W-1:0]          row_reg, row_next;

    mdh_cordic #(.STEPS(STEPS)) u_cordic_q (
        .clk(clk), .adv(adv), .ang(job.q), .sin_v(sq), .cos_v(cq));
    mdh_cordic #(.STEPS(STEPS)) u_cordic_a (
        .clk(clk), .adv(adv), .ang(job.a), .sin_v(sa), .cos_v(ca));
    mdh_cordic #(.STEPS(STEPS)) u_cordic_g (
        .clk(clk), .adv(adv), .ang(job.g), .sin_v(sg), .cos_v(cg));

    assign fire    = matrix.valid && matrix.ready;
    assign take    = v3_reg && (!full_reg || (fire && row_reg == mdh_pkg::ROW_LAST));
    // hold the whole pipe while a finished matrix waits for the output stage
    assign adv     = !v3_reg || take;
    assign job_pop = adv && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= '0;
            tv_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg <= {cv_reg[STEPS-2:0], job_valid};
            tv_reg <= cv_reg[STEPS-1];
            v1_reg <= tv_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        logic signed [P:0] s;
        s = (P+1)'(cgcq2_reg) - (P+1)'(sgcasq_reg);
        m3_next[0].c0 = mdh_pkg::sat_entry(mdh_pkg::rot_round(s));
        s = -(P+1)'(cgsq2_reg) - (P+1)'(sgcacq_reg);
        m3_next[0].c1 = mdh_pkg::sat_entry(mdh_pkg::rot_round(s));
        m3_next[0].c2 = mdh_pkg::sat_entry(mdh_pkg::rot_round((P+1)'(sgsa2_reg)));
        m3_next[0].c3 = mdh_pkg::sat_entry(
            mdh_pkg::len_round(50'(dcg2_reg) + 50'(rsgsa_reg)));

        s = (P+1)'(sgcq2_reg) + (P+1)'(cgcasq_reg);
        m3_next[1].c0 = mdh_pkg::sat_entry(mdh_pkg::rot_round(s));
        s = -(P+1)'(sgsq2_reg) + (P+1)'(cgcacq_reg);
        m3_next[1].c1 = mdh_pkg::sat_entry(mdh_pkg::rot_round(s));
        m3_next[1].c2 = mdh_pkg::sat_entry(mdh_pkg::rot_round(-(P+1)'(cgsa2_reg)));
        m3_next[1].c3 = mdh_pkg::sat_entry(
            mdh_pkg::len_round(50'(dsg2_reg) - 50'(rcgsa_reg)));

        m3_next[2].c0 = mdh_pkg::sat_entry(mdh_pkg::rot_round((P+1)'(sasq2_reg)));
        m3_next[2].c1 = mdh_pkg::sat_entry(mdh_pkg::rot_round((P+1)'(sacq2_reg)));
        m3_next[2].c2 = mdh_pkg::sat_entry(mdh_pkg::rot_round((P+1)'(ca2_reg)));
        // b joins after the rounding of r * cos(alpha)
        m3_next[2].c3 = mdh_pkg::sat_entry(
            mdh_pkg::len_round(50'(rca2_reg)) + 48'(b2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                ln_reg[i] <= (i == 0) ? job.len : ln_reg[(i == 0) ? 0 : i-1];
            end

            sq_reg <= P'(sq);
            cq_reg <= P'(cq);
            sa_reg <= P'(sa);
            ca_reg <= P'(ca);
            sg_reg <= P'(sg);
            cg_reg <= P'(cg);
            tl_reg <= ln_reg[STEPS-1];

            sgca_reg <= mdh_pkg::mul30(sg_reg, ca_reg);
            cgca_reg <= mdh_pkg::mul30(cg_reg, ca_reg);
            sgsa_reg <= mdh_pkg::mul30(sg_reg, sa_reg);
            cgsa_reg <= mdh_pkg::mul30(cg_reg, sa_reg);
            cgcq_reg <= mdh_pkg::mul30(cg_reg, cq_reg);
            cgsq_reg <= mdh_pkg::mul30(cg_reg, sq_reg);
            sgcq_reg <= mdh_pkg::mul30(sg_reg, cq_reg);
            sgsq_reg <= mdh_pkg::mul30(sg_reg, sq_reg);
            sasq_reg <= mdh_pkg::mul30(sa_reg, sq_reg);
            sacq_reg <= mdh_pkg::mul30(sa_reg, cq_reg);
            sq1_reg  <= sq_reg;
            cq1_reg  <= cq_reg;
            ca1_reg  <= ca_reg;
            dcg_reg  <= tl_reg.d * cg_reg;
            dsg_reg  <= tl_reg.d * sg_reg;
            rca_reg  <= tl_reg.r * ca_reg;
            r1_reg   <= tl_reg.r;
            b1_reg   <= tl_reg.b;

            sgcasq_reg <= mdh_pkg::mul30(sgca_reg, sq1_reg);
            sgcacq_reg <= mdh_pkg::mul30(sgca_reg, cq1_reg);
            cgcasq_reg <= mdh_pkg::mul30(cgca_reg, sq1_reg);
            cgcacq_reg <= mdh_pkg::mul30(cgca_reg, cq1_reg);
            rsgsa_reg  <= r1_reg * sgsa_reg;
            rcgsa_reg  <= r1_reg * cgsa_reg;
            cgcq2_reg  <= cgcq_reg;
            cgsq2_reg  <= cgsq_reg;
            sgcq2_reg  <= sgcq_reg;
            sgsq2_reg  <= sgsq_reg;
            sasq2_reg  <= sasq_reg;
            sacq2_reg  <= sacq_reg;
            sgsa2_reg  <= sgsa_reg;
            cgsa2_reg  <= cgsa_reg;
            ca2_reg    <= ca1_reg;
            dcg2_reg   <= dcg_reg;
            dsg2_reg   <= dsg_reg;
            rca2_reg   <= rca_reg;
            b2_reg     <= b1_reg;

            m3_reg <= m3_next;
        end
        if (take)
        begin
            mat_reg <= m3_reg;
        end
    end

    always_comb
    begin
        full_next = full_reg;
        row_next  = row_reg;
        if (take)
        begin
            full_next = 1'b1;
            row_next  = '0;
        end
        else if (fire)
        begin
            row_next = row_reg + 1'b1;
            if (row_reg == mdh_pkg::ROW_LAST)
            begin
                full_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= '0;
        end
        else
        begin
            full_reg <= full_next;
            row_reg  <= row_next;
        end
    end

    assign matrix.valid     = full_reg;
    assign matrix.row_index = row_reg;
    assign matrix.last_row  = (row_reg == mdh_pkg::ROW_LAST);

    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                matrix.entry_first  = mat_reg[0].c0;
                matrix.entry_second = mat_reg[0].c1;
                matrix.entry_third  = mat_reg[0].c2;
                matrix.entry_fourth = mat_reg[0].c3;
            end
            2'd1:
            begin
                matrix.entry_first  = mat_reg[1].c0;
                matrix.entry_second = mat_reg[1].c1;
                matrix.entry_third  = mat_reg[1].c2;
                matrix.entry_fourth = mat_reg[1].c3;
            end
            2'd2:
            begin
                matrix.entry_first  = mat_reg[2].c0;
                matrix.entry_second = mat_reg[2].c1;
                matrix.entry_third  = mat_reg[2].c2;
                matrix.entry_fourth = mat_reg[2].c3;
            end
            default:
            begin
                matrix.entry_first  = '0;
                matrix.entry_second = '0;
                matrix.entry_third  = '0;
                matrix.entry_fourth = mdh_pkg::ENTRY_ONE;
            end
        endcase
    end

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !adv |=> v3_reg)
        else $error("finished matrix dropped while stalled");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cv_reg) && $stable(v2_reg))
        else $error("pipeline moved while stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        fire && row_reg == mdh_pkg::ROW_LAST && !take |=> !full_reg)
        else $error("output stage kept a matrix after its last row");

endmodule

/* rtl/modified_dh_joint_transform.sv */
// Modified Denavit-Hartenberg joint transform: top level.
`timescale 1ns / 1ps

// Takes one joint item (q, alpha, gamma, d, r, b) and returns its 4x4 modified DH
// transform as four row items, rows 0 to 3, last_row marking row 3 (0,0,0,16384).
// A joint can be accepted every cycle while the 4-deep queue is not full; sustained
// throughput is limited by the four rows of each joint leaving through the one output
// port. Three CORDIC pipelines of CORDIC_STEPS stages run side by side, followed by
// four product and rounding stages.
module modified_dh_joint_transform #(
    parameter int CORDIC_STEPS = mdh_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mdh_in_if.sink      joint,
    mdh_out_if.source   matrix
);

    mdh_pkg::job_t head;
    logic          head_valid;
    logic          pop;

    mdh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .joint      (joint),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    mdh_back #(.STEPS(CORDIC_STEPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head),
        .job_valid (head_valid),
        .job_pop   (pop),
        .matrix    (matrix)
    );

endmodule

/* tb/mdh_joint_checker.sv */
// Checker for the joint transform: predicts matrix rows per joint and compares.
`timescale 1ns / 1ps

module mdh_joint_checker (
    input  logic clk,
    input  logic rst_n,
    mdh_in_if    joint,
    mdh_out_if   matrix,
    output int   fail_count,
    output int   rows_pending
);
    import mdh_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] row;
        entry_t           e0;
        entry_t           e1;
        entry_t           e2;
        entry_t           e3;
        logic             last;
    } mdh_row_s;

    mdh_row_s row_queue[$];

    localparam int STEPS = CORDIC_STEPS_DEF;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    // atan(2^-i) at scale 2^-40 from the Taylor series at scale 2^-62; pi/4 for i = 0
    function automatic longint arctan_step(int i);
        longint unsigned acc;
        longint unsigned term;
        int e;
        acc = 0;
        if (i == 0)
            acc = 64'h3243F6A8885A308D;
        else
            for (int k = 0; k < 64; k++)
            begin
                e = i * (2 * k + 1);
                if (e > 62)
                    break;
                term = (64'd1 << (62 - e)) / (2 * k + 1);
                if (k % 2 == 1)
                    acc -= term;
                else
                    acc += term;
            end
        return longint'((acc + (64'd1 << 21)) >> 22);
    endfunction

    task automatic rotate(input logic signed [15:0] ang, output longint s, output longint c);
        longint pi40, hpi40, z, x, y, nx, a;
        logic flip;
        pi40 = longint'((64'h3243F6A8885A308D + (64'd1 << 19)) >> 20);
        hpi40 = longint'((64'h3243F6A8885A308D + (64'd1 << 20)) >> 21);
        z = longint'(ang) * 134217728;
        x = 64'sh26DD3B6A;
        y = 0;
        flip = 0;
        if (z > hpi40)
        begin
            z -= pi40;
            flip = 1;
        end
        else if (z < -hpi40)
        begin
            z += pi40;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            a = arctan_step(i);
            if (z >= 0)
            begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                z -= a;
            end
            else
            begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                z += a;
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint q30_product(longint a, longint b);
        return shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic entry_t clamp(longint v);
        if (v > 131071)
            return entry_t'(131071);
        if (v < -131072)
            return entry_t'(-131072);
        return entry_t'(v);
    endfunction

    function automatic entry_t rot_entry(longint v);
        return clamp(shr(v + 32768, 16));
    endfunction

    function automatic entry_t len_entry(longint v);
        return clamp(shr(v + (64'sd1 <<< 29), 30));
    endfunction

    task automatic predict_matrix(input logic signed [15:0] q, al, ga, dd, rr, bb);
        longint sq, cq, sa, ca, sg, cg, sgca, cgca, sgsa, cgsa, d, r, b;
        mdh_row_s m;
        rotate(q, sq, cq);
        rotate(al, sa, ca);
        rotate(ga, sg, cg);
        d = dd;
        r = rr;
        b = bb;
        sgca = q30_product(sg, ca);
        cgca = q30_product(cg, ca);
        sgsa = q30_product(sg, sa);
        cgsa = q30_product(cg, sa);
        m.last = 0;
        m.row = 0;
        m.e0 = rot_entry(q30_product(cg, cq) - q30_product(sgca, sq));
        m.e1 = rot_entry(-q30_product(cg, sq) - q30_product(sgca, cq));
        m.e2 = rot_entry(sgsa);
        m.e3 = len_entry(d * cg + r * sgsa);
        row_queue.push_back(m);
        m.row = 1;
        m.e0 = rot_entry(q30_product(sg, cq) + q30_product(cgca, sq));
        m.e1 = rot_entry(-q30_product(sg, sq) + q30_product(cgca, cq));
        m.e2 = rot_entry(-cgsa);
        m.e3 = len_entry(d * sg - r * cgsa);
        row_queue.push_back(m);
        m.row = 2;
        m.e0 = rot_entry(q30_product(sa, sq));
        m.e1 = rot_entry(q30_product(sa, cq));
        m.e2 = rot_entry(ca);
        m.e3 = clamp(shr(r * ca + (64'sd1 <<< 29), 30) + b);
        row_queue.push_back(m);
        m.row = ROW_LAST;
        m.e0 = 0;
        m.e1 = 0;
        m.e2 = 0;
        m.e3 = ENTRY_ONE;
        m.last = 1;
        row_queue.push_back(m);
    endtask

    task automatic compare(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial
        fail_count = 0;

    assign rows_pending = row_queue.size();

    always @(posedge clk)
    begin
        mdh_row_s w;
        if (rst_n)
        begin
            if (joint.valid && joint.ready)
                predict_matrix(joint.joint_angle, joint.twist_alpha, joint.offset_gamma,
                               joint.length_d, joint.offset_r, joint.offset_b);
            if (matrix.valid && matrix.ready)
            begin
                if (row_queue.size() == 0)
                begin
                    $error("row item with none expected");
                    fail_count++;
                end
                else
                begin
                    w = row_queue.pop_front();
                    compare("row_index", w.row, matrix.row_index);
                    compare("entry_first", w.e0, matrix.entry_first);
                    compare("entry_second", w.e1, matrix.entry_second);
                    compare("entry_third", w.e2, matrix.entry_third);
                    compare("entry_fourth", w.e3, matrix.entry_fourth);
                    compare("last_row", w.last, matrix.last_row);
                end
            end
        end
    end
endmodule

/* tb/modified_dh_joint_transform_test.sv */
// Testbench top: drives joint items, paces the row sink and gives the verdict.
`timescale 1ns / 1ps

module modified_dh_joint_transform_test;
    import mdh_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   rows_pending;
    logic hold_rows;

    mdh_in_if  joint();
    mdh_out_if matrix();

    modified_dh_joint_transform DUT (.clk(clk), .rst_n(rst_n), .joint(joint), .matrix(matrix));
    mdh_joint_checker checker_i (.clk(clk), .rst_n(rst_n), .joint(joint), .matrix(matrix),
                                 .fail_count(fail_count), .rows_pending(rows_pending));

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_angle();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6)
            return 16'($urandom);
        if (p < 8)  // near plus or minus a quarter turn
            return 16'($signed(($urandom_range(0, 1) ? 12868 : -12868) + $urandom_range(0, 8)) - 4);
        return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic send_joint(input logic [15:0] q, al, ga, dd, rr, bb);
        joint.valid <= 1;
        joint.joint_angle <= q;
        joint.twist_alpha <= al;
        joint.offset_gamma <= ga;
        joint.length_d <= dd;
        joint.offset_r <= rr;
        joint.offset_b <= bb;
        @(posedge clk);
        while (!joint.ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            joint.valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Row sink: random stalls, or a hard hold while hold_rows is set.
    initial
    begin
        matrix.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rows)
                matrix.ready <= 0;
            else
                matrix.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [15:0] sp[6];
        hold_rows = 0;
        rst_n = 0;
        joint.valid = 0;
        joint.joint_angle = 0;
        joint.twist_alpha = 0;
        joint.offset_gamma = 0;
        joint.length_d = 0;
        joint.offset_r = 0;
        joint.offset_b = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: zeros, extremes, quarter-turn edges, saturating lengths.
        send_joint(0, 0, 0, 0, 0, 0);
        send_joint(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_joint(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_joint(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_joint(12868, 12868, 12868, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_joint(12869, -12869, 12867, 16'h8000, 16'h7FFF, 16'h8000);
        send_joint(-12868, 12867, -12867, 1000, -1000, 500);
        send_joint(25736, -25736, 25735, 16'h5555, 16'hAAAA, 16'h5555);
        send_joint(0, 12868, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_joint(0, -12868, 0, 16'h8000, 16'h7FFF, 16'h8000);
        send_joint(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_joint(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        // Hold the sink long so the pipeline and input queue fill and stall.
        hold_rows = 1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_rows = 0;
            end
            for (int i = 0; i < 40; i++)
                send_joint(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom));
        join

        // Pause until the block drains.
        joint.valid <= 0;
        while (rows_pending != 0)
            @(posedge clk);

        for (int n = 0; n < 220; n++)
        begin
            sp[0] = pick_angle();
            sp[1] = pick_angle();
            sp[2] = pick_angle();
            for (int k = 3; k < 6; k++)
                sp[k] = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000)
                                                    : 16'($urandom);
            send_joint(sp[0], sp[1], sp[2], sp[3], sp[4], sp[5]);
            idle_gap((n % 50 < 10) ? 0 : gap_len());
        end
        joint.valid <= 0;

        while (rows_pending != 0)
            @(posedge clk);
        repeat (CORDIC_STEPS_DEF + 20) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
